// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the map store RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/core/tom_pkg.sv -----
// Shared constants, types and helpers of the tiled occupancy map store
package tom_pkg;

  localparam int unsigned TILES = 16;
  localparam int unsigned IDX_W = (TILES > 1) ? $clog2(TILES) : 1;
  localparam int unsigned CNT_W = $clog2(TILES + 1);
  localparam int unsigned COORD_W = 7;
  localparam int unsigned CELLS_W = 18;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } tom_cmd_t;

  typedef struct packed {
    logic match;
    logic scan_last;
    logic out_free;
  } tom_sts_t;

  typedef struct packed {
    logic [COORD_W-1:0] base;
    logic [1:0]         off;
  } tom_floor_t;

  // Floor a signed coordinate to a multiple of three; base is kept wrapped
  function automatic tom_floor_t tom_floor3(input logic [COORD_W-1:0] raw);
    logic [7:0]  u;
    logic [15:0] prod;
    logic [5:0]  q;
    logic [7:0]  q3;
    logic [7:0]  rem;
    tom_floor_t  res;
    u    = {raw[COORD_W-1], raw} + 8'd66;
    prod = 16'(u) * 16'd171;
    q    = prod[14:9];
    q3   = 8'({2'b00, q}) + 8'({1'b0, q, 1'b0});
    rem  = u - q3;
    res.base = 7'(q3 + 8'd62);
    res.off  = rem[1:0];
    return res;
  endfunction

endpackage

// ----- rtl/core/tom_ctrl.sv -----
// Sequencer of the map store: accept, table search, commit
module tom_ctrl import tom_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tom_sts_t sts_i,
  output tom_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    state_d    = state_q;
    ready_d    = ready_q;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (ready_q && in_valid_i) begin
          cmd_o.load = 1'b1;
          ready_d    = 1'b0;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (sts_i.match || sts_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the output register can take the word
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          ready_d      = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;

endmodule

// ----- rtl/core/tom_dpath.sv -----
// Tile table, search pointer and result register of the map store
module tom_dpath import tom_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tom_cmd_t           cmd_i,
  output tom_sts_t           sts_o,
  input  logic               mode_i,
  input  logic [COORD_W-1:0] coord_x_i,
  input  logic [COORD_W-1:0] coord_y_i,
  input  logic [1:0]         cell_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [1:0]         cell_out_o,
  output logic [1:0]         status_o
);

  logic [TILES-1:0]   tile_valid_q;
  logic [COORD_W-1:0] tile_base_x_q [TILES];
  logic [COORD_W-1:0] tile_base_y_q [TILES];
  logic [CELLS_W-1:0] tile_cells_q  [TILES];
  logic [CNT_W-1:0]   tiles_used_q;

  logic               mode_q;
  logic [1:0]         value_q;
  logic [COORD_W-1:0] bx_q, by_q;
  logic [3:0]         cell_q;
  logic [IDX_W-1:0]   scan_q, idx_q;
  logic               hit_q;

  logic               out_valid_q;
  logic               found_q;
  logic [1:0]         cell_out_q, status_q;

  tom_floor_t         fx, fy;
  logic [3:0]         cell_d;
  logic               table_full;
  logic [IDX_W-1:0]   alloc_idx;
  logic [CELLS_W-1:0] hit_cells, cell_mask, cell_ins;
  logic [4:0]         shift;

  assign fx     = tom_floor3(coord_x_i);
  assign fy     = tom_floor3(coord_y_i);
  assign cell_d = 4'(fx.off) + 4'({fy.off, 1'b0}) + 4'(fy.off);

  assign sts_o.match     = tile_valid_q[scan_q] && (tile_base_x_q[scan_q] == bx_q)
                           && (tile_base_y_q[scan_q] == by_q);
  assign sts_o.scan_last = (scan_q == IDX_W'(TILES - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign table_full = (tiles_used_q >= CNT_W'(TILES));
  assign alloc_idx  = tiles_used_q[IDX_W-1:0];
  assign hit_cells  = tile_cells_q[idx_q];
  assign shift      = {cell_q, 1'b0};
  assign cell_mask  = CELLS_W'(2'b11) << shift;
  assign cell_ins   = CELLS_W'(value_q) << shift;

  // item capture and table search
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      value_q <= cell_value_i;
      bx_q    <= fx.base;
      by_q    <= fy.base;
      cell_q  <= cell_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      idx_q  <= '0;
      hit_q  <= 1'b0;
    end else if (cmd_i.load) begin
      scan_q <= '0;
      hit_q  <= 1'b0;
    end else if (cmd_i.step) begin
      if (sts_o.match) begin
        hit_q <= 1'b1;
        idx_q <= scan_q;
      end else if (!sts_o.scan_last) begin
        scan_q <= scan_q + IDX_W'(1);
      end
    end
  end

  // tile table update on a write-mode commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_valid_q <= TILES'(1);
      tiles_used_q <= CNT_W'(1);
      for (int i = 0; i < TILES; i++) begin
        tile_base_x_q[i] <= '0;
        tile_base_y_q[i] <= '0;
        tile_cells_q[i]  <= '0;
      end
    end else if (cmd_i.commit && mode_q) begin
      if (hit_q) begin
        tile_cells_q[idx_q] <= (hit_cells & ~cell_mask) | cell_ins;
      end else if (!table_full) begin
        tile_valid_q[alloc_idx]  <= 1'b1;
        tile_base_x_q[alloc_idx] <= bx_q;
        tile_base_y_q[alloc_idx] <= by_q;
        tile_cells_q[alloc_idx]  <= cell_ins;
        tiles_used_q             <= tiles_used_q + CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      found_q    <= hit_q;
      cell_out_q <= 2'b00;
      status_q   <= STAT_OK;
      if (!mode_q) begin
        if (hit_q) begin
          cell_out_q <= hit_cells[shift +: 2];
        end else begin
          status_q <= STAT_MISSING;
        end
      end else if (!hit_q && table_full) begin
        status_q <= STAT_FULL;
      end else begin
        cell_out_q <= value_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign cell_out_o  = cell_out_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/core/tiled_occupancy_map_store.sv -----
// From accept, the table is searched one entry per cycle until the tile is found or the table
//   is exhausted, then committed once the output register is free; one word in flight at a time.
// The result register lets the next word be accepted while a result waits to be taken.
// Reset (rst_ni, async, active low): table holds only tile (0,0), cleared; output empty.
`include "assert_macros.svh"
module tiled_occupancy_map_store import tom_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // coord_x[6:0], coord_y[13:7], cell_value[15:14]
  input  logic        s_axis_tuser,   // mode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // found[0], cell_out[2:1], status[4:3], zero[7:5]
);

  tom_cmd_t   cmd;
  tom_sts_t   sts;
  logic       found;
  logic [1:0] cell_out, status;
  logic       in_fire;

  tom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tom_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (s_axis_tuser),
    .coord_x_i    (s_axis_tdata[6:0]),
    .coord_y_i    (s_axis_tdata[13:7]),
    .cell_value_i (s_axis_tdata[15:14]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .found_o      (found),
    .cell_out_o   (cell_out),
    .status_o     (status)
  );

  assign m_axis_tdata = {3'b000, status, cell_out, found};
  assign in_fire      = s_axis_tvalid && s_axis_tready;

  `ASSERT_PROP(a_commit_room, clk_i, rst_ni, cmd.commit |-> sts.out_free, "commit with output full")
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, in_fire |=> !s_axis_tready, "ready while busy")
  `ASSERT_PROP(a_commit_shows, clk_i, rst_ni, cmd.commit |=> m_axis_tvalid, "result not presented")
  `ASSERT_NEVER(a_cmd_excl, clk_i, rst_ni, !$onehot0({cmd.load, cmd.step, cmd.commit}), "overlap")

endmodule
